FILE: hdl/assert_macros.svh
// Assertion macros shared by the deframer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must never be true at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed: forbidden condition seen");

// whenever ante holds, cons holds at the same edge
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

`endif

FILE: hdl/afsd_pkg.sv
// Shared types, constants and helpers of the ADC frame stream deframer
package afsd_pkg;

    localparam int MAX_FRAME_SAMPLES = 4095;
    localparam int NUM_FRONTENDS     = 4;
    localparam int CMD_DEPTH         = 4;

    localparam logic [11:0] COUNT_CAP =
        (MAX_FRAME_SAMPLES < 4095) ? 12'(MAX_FRAME_SAMPLES) : 12'd4095;

    localparam logic [23:0] HDR_TAG       = 24'h414443;
    localparam logic [31:0] TRAILER_WORD  = 32'hfafafafa;
    localparam logic [63:0] MASK_RESET    = 64'hffff_ffff_ffff_ffff;
    localparam logic [11:0] MIN_RESET     = 12'd64;

    localparam logic REG_ACTIVE_MASK = 1'b0;
    localparam logic REG_MIN_SAMPLES = 1'b1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLOSE  = 1'b1;

    // slot order: A sample hi, A sample lo, A close, B sample hi, B sample lo, B close
    localparam int NUM_SLOTS = 6;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] slot_mask;
        logic [31:0]          word_a;
        logic [31:0]          word_b;
        logic [11:0]          pos_a1;
        logic [11:0]          pos_a2;
        logic [11:0]          pos_b1;
        logic [11:0]          pos_b2;
        logic [11:0]          cnt_a;
        logic [11:0]          cnt_b;
        logic                 kept_a;
        logic [7:0]           fe_a;
        logic [7:0]           ch_a;
        logic [7:0]           fe_b;
        logic [7:0]           ch_b;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic logic [11:0] sat_inc(input logic [11:0] x);
        sat_inc = (x < COUNT_CAP) ? x + 12'd1 : x;
    endfunction

    function automatic logic [15:0] swap_hi(input logic [31:0] w);
        swap_hi = {w[23:16], w[31:24]};
    endfunction

    function automatic logic [15:0] swap_lo(input logic [31:0] w);
        swap_lo = {w[7:0], w[15:8]};
    endfunction

endpackage

FILE: hdl/afsd_front.sv
// Front end: holds the pending word, classifies each word and builds a result command
module afsd_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [31:0]        raw_word,
    input  logic               buffer_end,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [63:0]        cfg_data,
    output afsd_pkg::cmd_t     cmd,
    output logic               cmd_we
);

    logic [31:0] held_word_reg, held_word_next;
    logic        held_valid_reg, held_valid_next;
    logic        await_fe_reg, await_fe_next;
    logic        ch_en_reg, ch_en_next;
    logic [7:0]  fe_reg, fe_next;
    logic [7:0]  chan_reg, chan_next;
    logic [11:0] count_reg, count_next;
    logic [63:0] mask_reg;
    logic [11:0] min_reg;

    logic        hv_a, aw_a, en_a;
    logic [31:0] hw_a;
    logic [7:0]  fe_a, ch_a;
    logic        flush_a, close_a, flush_b;
    logic [11:0] pos_a1, pos_a2, cnt_close_a, cnt_after_a;
    logic [11:0] pos_b1, pos_b2, cnt_b;
    logic        is_hdr, is_trl;

    function automatic logic chan_active(input logic [63:0] m, input logic [7:0] fe,
                                         input logic [7:0] ch);
        chan_active = (fe < 8'(afsd_pkg::NUM_FRONTENDS)) && (ch < 8'd16)
                      && m[{fe[1:0], ch[3:0]}];
    endfunction

    always_comb
    begin
        is_hdr  = (raw_word[31:8] == afsd_pkg::HDR_TAG);
        is_trl  = (raw_word == afsd_pkg::TRAILER_WORD);
        hw_a    = held_word_reg;
        hv_a    = held_valid_reg;
        aw_a    = await_fe_reg;
        en_a    = ch_en_reg;
        fe_a    = fe_reg;
        ch_a    = chan_reg;
        flush_a = 1'b0;
        close_a = 1'b0;
        if (await_fe_reg)
        begin
            fe_a = raw_word[23:16];
            en_a = chan_active(mask_reg, raw_word[23:16], chan_reg);
            aw_a = 1'b0;
        end
        else if (!held_valid_reg)
        begin
            hw_a = raw_word;
            hv_a = 1'b1;
        end
        else if (is_hdr)
        begin
            hv_a    = 1'b0;
            close_a = 1'b1;
            ch_a    = raw_word[7:0];
            aw_a    = 1'b1;
        end
        else if (is_trl)
        begin
            flush_a = ch_en_reg;
            hv_a    = 1'b0;
            close_a = 1'b1;
        end
        else
        begin
            flush_a = ch_en_reg;
            hw_a    = raw_word;
            hv_a    = 1'b1;
        end

        pos_a1      = count_reg;
        pos_a2      = afsd_pkg::sat_inc(count_reg);
        cnt_close_a = flush_a ? afsd_pkg::sat_inc(pos_a2) : count_reg;
        cnt_after_a = close_a ? 12'd0 : cnt_close_a;

        flush_b = buffer_end && hv_a && en_a;
        pos_b1  = cnt_after_a;
        pos_b2  = afsd_pkg::sat_inc(cnt_after_a);
        cnt_b   = flush_b ? afsd_pkg::sat_inc(pos_b2) : cnt_after_a;

        held_word_next = hw_a;
        fe_next        = fe_a;
        chan_next      = ch_a;
        if (buffer_end)
        begin
            held_valid_next = 1'b0;
            await_fe_next   = 1'b0;
            ch_en_next      = 1'b1;
            count_next      = 12'd0;
        end
        else
        begin
            held_valid_next = hv_a;
            await_fe_next   = aw_a;
            ch_en_next      = en_a;
            count_next      = cnt_after_a;
        end

        cmd.slot_mask = {buffer_end, flush_b, flush_b, close_a, flush_a, flush_a};
        cmd.word_a    = held_word_reg;
        cmd.word_b    = hw_a;
        cmd.pos_a1    = pos_a1;
        cmd.pos_a2    = pos_a2;
        cmd.pos_b1    = pos_b1;
        cmd.pos_b2    = pos_b2;
        cmd.cnt_a     = cnt_close_a;
        cmd.cnt_b     = cnt_b;
        cmd.kept_a    = ch_en_reg && (cnt_close_a > min_reg);
        cmd.fe_a      = fe_reg;
        cmd.ch_a      = chan_reg;
        cmd.fe_b      = fe_a;
        cmd.ch_b      = ch_a;
        cmd_we        = accept && (cmd.slot_mask != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_word_reg  <= '0;
            held_valid_reg <= 1'b0;
            await_fe_reg   <= 1'b0;
            ch_en_reg      <= 1'b1;
            fe_reg         <= '0;
            chan_reg       <= '0;
            count_reg      <= '0;
        end
        else if (accept)
        begin
            held_word_reg  <= held_word_next;
            held_valid_reg <= held_valid_next;
            await_fe_reg   <= await_fe_next;
            ch_en_reg      <= ch_en_next;
            fe_reg         <= fe_next;
            chan_reg       <= chan_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= afsd_pkg::MASK_RESET;
            min_reg  <= afsd_pkg::MIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                afsd_pkg::REG_ACTIVE_MASK: mask_reg <= cfg_data;
                afsd_pkg::REG_MIN_SAMPLES: min_reg  <= cfg_data[11:0];
                default:                   mask_reg <= mask_reg;
            endcase
        end
    end

`include "assert_macros.svh"

    // a header clears the pending word before the front-end word is awaited
    `ASSERT_IMPLIES(await_no_held, clk, rst_n, await_fe_reg, !held_valid_reg)

endmodule

FILE: hdl/afsd_cmd_fifo.sv
// Short command queue between the front end and the result sequencer
module afsd_cmd_fifo
#(
    parameter int DEPTH = afsd_pkg::CMD_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  afsd_pkg::cmd_t       wr_cmd,
    input  logic                 rd_en,
    output afsd_pkg::cmd_t       rd_cmd,
    output afsd_pkg::fifo_stat_t stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    afsd_pkg::cmd_t mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
        stat.full  = (count_reg == CW'(DEPTH));
        stat.empty = (count_reg == '0);
        rd_cmd     = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_cmd;
    end

`include "assert_macros.svh"

    `ASSERT_NEVER(fifo_no_overflow, clk, rst_n, wr_en && stat.full)
    `ASSERT_NEVER(fifo_no_underflow, clk, rst_n, rd_en && stat.empty)

endmodule

FILE: hdl/afsd_back.sv
// Back end: walks the slots of each command and drives the result register
module afsd_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  afsd_pkg::cmd_t       rd_cmd,
    input  afsd_pkg::fifo_stat_t stat,
    output logic                 rd_en,
    input  logic                 pop,
    output logic                 empty,
    output logic                 item_kind,
    output logic [15:0]          sample_value,
    output logic [11:0]          sample_position,
    output logic [7:0]           frontend_id,
    output logic [7:0]           adc_channel,
    output logic [11:0]          frame_count,
    output logic                 frame_kept,
    output logic                 last_of_run
);

    localparam int NS = afsd_pkg::NUM_SLOTS;
    localparam int SW = $clog2(NS);

    afsd_pkg::cmd_t cur_reg;
    logic [NS-1:0]  cur_mask_reg, cur_mask_next;
    logic           out_valid_reg, out_valid_next;
    logic           kind_reg, kind_next;
    logic [15:0]    value_reg, value_next;
    logic [11:0]    pos_reg, pos_next;
    logic [7:0]     fe_reg, fe_next;
    logic [7:0]     ch_reg, ch_next;
    logic [11:0]    cnt_reg, cnt_next;
    logic           kept_reg, kept_next;
    logic           last_reg, last_next;

    logic [SW-1:0]  sel;
    logic [NS-1:0]  rem;
    logic           adv, emit, need_load;

    function automatic logic [SW-1:0] first_set(input logic [NS-1:0] m);
        first_set = '0;
        for (int i = NS - 1; i >= 0; i--)
        begin
            if (m[i])
                first_set = SW'(i);
        end
    endfunction

    always_comb
    begin
        sel       = first_set(cur_mask_reg);
        rem       = cur_mask_reg & ~(NS'(1) << sel);
        adv       = !out_valid_reg || pop;
        emit      = adv && (cur_mask_reg != '0);
        need_load = (cur_mask_reg == '0) || (emit && (rem == '0));
        rd_en     = need_load && !stat.empty;

        if (rd_en)
            cur_mask_next = rd_cmd.slot_mask;
        else if (emit)
            cur_mask_next = rem;
        else
            cur_mask_next = cur_mask_reg;

        kind_next  = afsd_pkg::KIND_SAMPLE;
        value_next = '0;
        pos_next   = '0;
        fe_next    = cur_reg.fe_b;
        ch_next    = cur_reg.ch_b;
        cnt_next   = '0;
        kept_next  = 1'b0;
        last_next  = (rem == '0);
        case (sel)
            SW'(0):
            begin
                value_next = afsd_pkg::swap_hi(cur_reg.word_a);
                pos_next   = cur_reg.pos_a1;
                fe_next    = cur_reg.fe_a;
                ch_next    = cur_reg.ch_a;
            end
            SW'(1):
            begin
                value_next = afsd_pkg::swap_lo(cur_reg.word_a);
                pos_next   = cur_reg.pos_a2;
                fe_next    = cur_reg.fe_a;
                ch_next    = cur_reg.ch_a;
            end
            SW'(2):
            begin
                kind_next = afsd_pkg::KIND_CLOSE;
                cnt_next  = cur_reg.cnt_a;
                kept_next = cur_reg.kept_a;
                fe_next   = cur_reg.fe_a;
                ch_next   = cur_reg.ch_a;
            end
            SW'(3):
            begin
                value_next = afsd_pkg::swap_hi(cur_reg.word_b);
                pos_next   = cur_reg.pos_b1;
            end
            SW'(4):
            begin
                value_next = afsd_pkg::swap_lo(cur_reg.word_b);
                pos_next   = cur_reg.pos_b2;
            end
            default:
            begin
                kind_next = afsd_pkg::KIND_CLOSE;
                cnt_next  = cur_reg.cnt_b;
            end
        endcase

        if (emit)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mask_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_mask_reg  <= cur_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            cur_reg <= rd_cmd;
        if (emit)
        begin
            kind_reg  <= kind_next;
            value_reg <= value_next;
            pos_reg   <= pos_next;
            fe_reg    <= fe_next;
            ch_reg    <= ch_next;
            cnt_reg   <= cnt_next;
            kept_reg  <= kept_next;
            last_reg  <= last_next;
        end
    end

    assign empty           = !out_valid_reg;
    assign item_kind       = kind_reg;
    assign sample_value    = value_reg;
    assign sample_position = pos_reg;
    assign frontend_id     = fe_reg;
    assign adc_channel     = ch_reg;
    assign frame_count     = cnt_reg;
    assign frame_kept      = kept_reg;
    assign last_of_run     = last_reg;

endmodule

FILE: hdl/adc_frame_stream_deframer_top.sv
// ADC frame stream deframer: top level joining front end, command queue and back end
// A word's results pass through the command queue, the back end's current command register
// and the result register. Throughput: one word per cycle in while full is low, one result
// per cycle out while pop is held; the command queue (CMD_DEPTH entries) absorbs bursts.
// Reset (rst_n, asynchronous, active low) empties the queue and result register, clears the
// deframer state and sets the channel mask to all ones and the minimum frame size to 64.
module adc_frame_stream_deframer_top
#(
    parameter int CMD_DEPTH = afsd_pkg::CMD_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] raw_word,
    input  logic        buffer_end,
    output logic        empty,
    input  logic        pop,
    output logic        item_kind,
    output logic [15:0] sample_value,
    output logic [11:0] sample_position,
    output logic [7:0]  frontend_id,
    output logic [7:0]  adc_channel,
    output logic [11:0] frame_count,
    output logic        frame_kept,
    output logic        last_of_run,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    afsd_pkg::cmd_t       wr_cmd;
    afsd_pkg::cmd_t       rd_cmd;
    afsd_pkg::fifo_stat_t stat;
    logic                 wr_en;
    logic                 rd_en;
    logic                 accept;

    assign full   = stat.full;
    assign accept = push && !stat.full;

    afsd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .raw_word   (raw_word),
        .buffer_end (buffer_end),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (wr_cmd),
        .cmd_we     (wr_en)
    );

    afsd_cmd_fifo #(.DEPTH(CMD_DEPTH)) u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (wr_en),
        .wr_cmd (wr_cmd),
        .rd_en  (rd_en),
        .rd_cmd (rd_cmd),
        .stat   (stat)
    );

    afsd_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .rd_cmd          (rd_cmd),
        .stat            (stat),
        .rd_en           (rd_en),
        .pop             (pop),
        .empty           (empty),
        .item_kind       (item_kind),
        .sample_value    (sample_value),
        .sample_position (sample_position),
        .frontend_id     (frontend_id),
        .adc_channel     (adc_channel),
        .frame_count     (frame_count),
        .frame_kept      (frame_kept),
        .last_of_run     (last_of_run)
    );

endmodule

FILE: tb/sv/testbench.sv
// Testbench for adc_frame_stream_deframer_top: bursty word driver, stalling checker, predictor
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [31:0] word;
        logic        eob;
    } raw_in_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] value;
        logic [11:0] position;
        logic [7:0]  fe;
        logic [7:0]  ch;
        logic [11:0] count;
        logic        kept;
        logic        last;
    } deframed_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] raw_word = '0;
    logic        buffer_end = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        item_kind;
    logic [15:0] sample_value;
    logic [11:0] sample_position;
    logic [7:0]  frontend_id;
    logic [7:0]  adc_channel;
    logic [11:0] frame_count;
    logic        frame_kept;
    logic        last_of_run;
    logic        cfg_we = 1'b0;
    logic        cfg_index = afsd_pkg::REG_ACTIVE_MASK;
    logic [63:0] cfg_data = '0;

    adc_frame_stream_deframer_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .raw_word(raw_word),
        .buffer_end(buffer_end),
        .empty(empty),
        .pop(pop),
        .item_kind(item_kind),
        .sample_value(sample_value),
        .sample_position(sample_position),
        .frontend_id(frontend_id),
        .adc_channel(adc_channel),
        .frame_count(frame_count),
        .frame_kept(frame_kept),
        .last_of_run(last_of_run),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    raw_in_t   words_to_send[$];
    deframed_t predicted_results[$];
    int        mismatches = 0;
    int        results_seen = 0;
    int        cycles = 0;

    // deframer shadow state and registers
    logic [63:0] active_mask = afsd_pkg::MASK_RESET;
    logic [11:0] min_samples = afsd_pkg::MIN_RESET;
    logic [31:0] pend_word = '0;
    logic        pend_valid = 1'b0;
    logic        want_fe_word = 1'b0;
    logic        lane_on = 1'b1;
    logic [7:0]  cur_fe = '0;
    logic [7:0]  cur_ch = '0;
    logic [11:0] frame_samples = '0;

    deframed_t word_out [0:4];
    int        word_out_n;

    initial begin
        forever #1 clk = ~clk;
    end

    function automatic logic lane_active(input logic [7:0] fe, input logic [7:0] ch);
        if (fe >= 8'(afsd_pkg::NUM_FRONTENDS) || ch >= 8'd16)
            return 1'b0;
        return active_mask[{fe[1:0], ch[3:0]}];
    endfunction

    task automatic add_result(input logic kind, input logic [15:0] value,
                              input logic [11:0] position, input logic [11:0] count,
                              input logic kept);
        deframed_t r;
        r.kind = kind;
        r.value = value;
        r.position = position;
        r.fe = cur_fe;
        r.ch = cur_ch;
        r.count = count;
        r.kept = kept;
        r.last = 1'b0;
        word_out[word_out_n] = r;
        word_out_n++;
    endtask

    task automatic add_sample(input logic [15:0] value);
        add_result(afsd_pkg::KIND_SAMPLE, value, frame_samples, 12'd0, 1'b0);
        if (frame_samples < afsd_pkg::COUNT_CAP)
            frame_samples++;
    endtask

    task automatic flush_pending();
        if (pend_valid && lane_on)
        begin
            add_sample({pend_word[23:16], pend_word[31:24]});
            add_sample({pend_word[7:0], pend_word[15:8]});
        end
        pend_valid = 1'b0;
    endtask

    task automatic close_frame(input logic discard);
        add_result(afsd_pkg::KIND_CLOSE, 16'd0, 12'd0, frame_samples,
                   !discard && lane_on && (frame_samples > min_samples));
        frame_samples = '0;
    endtask

    task automatic deframe_word(input logic [31:0] w, input logic eob);
        word_out_n = 0;
        if (want_fe_word)
        begin
            cur_fe = w[23:16];
            lane_on = lane_active(cur_fe, cur_ch);
            want_fe_word = 1'b0;
        end
        else if (!pend_valid)
        begin
            pend_word = w;
            pend_valid = 1'b1;
        end
        else if (w[31:8] == afsd_pkg::HDR_TAG)
        begin
            pend_valid = 1'b0;
            close_frame(1'b0);
            cur_ch = w[7:0];
            want_fe_word = 1'b1;
        end
        else if (w == afsd_pkg::TRAILER_WORD)
        begin
            flush_pending();
            close_frame(1'b0);
        end
        else
        begin
            flush_pending();
            pend_word = w;
            pend_valid = 1'b1;
        end
        if (eob)
        begin
            flush_pending();
            close_frame(1'b1);
            want_fe_word = 1'b0;
            lane_on = 1'b1;
        end
        if (word_out_n > 0)
            word_out[word_out_n - 1].last = 1'b1;
        for (int i = 0; i < word_out_n; i++)
            predicted_results = {predicted_results, word_out[i]};
    endtask

    // word driver: bursts of random length, random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin
        logic send;
        if (rst_n)
        begin
            if (push && !full)
            begin
                deframe_word(raw_word, buffer_end);
                void'(words_to_send.pop_front());
                if (burst_left > 0)
                    burst_left--;
            end
            if (gap_left > 0)
                gap_left--;
            else if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            send = (gap_left == 0) && (words_to_send.size() != 0);
            push <= send;
            if (send)
            begin
                raw_word <= words_to_send[0].word;
                buffer_end <= words_to_send[0].eob;
            end
        end
    end

    function automatic string describe(input deframed_t r);
        return $sformatf("kind=%0d val=%h pos=%0d fe=%0d ch=%0d cnt=%0d kept=%0d last=%0d",
                         r.kind, r.value, r.position, r.fe, r.ch, r.count, r.kept, r.last);
    endfunction

    task automatic flag_mismatch(input string what, input deframed_t want,
                                 input deframed_t got);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch (%s) at result %0d", what, results_seen);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
        end
    endtask

    // result checker with its own stall pattern and one long hold-off
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    logic [15:0] pop_pattern = '1;
    int          pattern_age = 0;
    int          pattern_bit = 0;

    always @(posedge clk)
    begin
        deframed_t got;
        deframed_t want;
        logic      pop_next;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                got.kind = item_kind;
                got.value = sample_value;
                got.position = sample_position;
                got.fe = frontend_id;
                got.ch = adc_channel;
                got.count = frame_count;
                got.kept = frame_kept;
                got.last = last_of_run;
                results_seen++;
                if (predicted_results.size() == 0)
                    flag_mismatch("unexpected word", '0, got);
                else
                begin
                    want = predicted_results.pop_front();
                    if (got !== want)
                        flag_mismatch("field", want, got);
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop_next = 1'b0;
            end
            else if (!hold_done && words_to_send.size() > 60 && results_seen > 30)
            begin
                hold_left = 300;
                hold_done = 1'b1;
                pop_next = 1'b0;
            end
            else
            begin
                if (pattern_age == 0)
                begin
                    pop_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff
                                                              : (16'($urandom) | 16'h0001);
                    pattern_age = $urandom_range(16, 96);
                end
                pattern_age--;
                pop_next = pop_pattern[pattern_bit];
                pattern_bit = (pattern_bit + 1) % 16;
            end
            pop <= pop_next;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL adc_frame_stream_deframer_top");
            $finish;
        end
    end

    task automatic queue_word(input logic [31:0] w, input logic eob);
        raw_in_t item;
        item.word = w;
        item.eob = eob;
        words_to_send = {words_to_send, item};
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == afsd_pkg::REG_ACTIVE_MASK)
            active_mask = data;
        else
            min_samples = data[11:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        while (words_to_send.size() != 0 || push || predicted_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // mostly well-formed frames with random content, plus stray words
    task automatic queue_random_words(input int target);
        int          queued;
        int          n;
        logic [7:0]  ch;
        logic [7:0]  fe;
        queued = 0;
        while (queued < target)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    queue_word($urandom, 1'b0);
                    queued++;
                end
                ch = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
                fe = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
                queue_word({afsd_pkg::HDR_TAG, ch}, 1'b0);
                queue_word({8'($urandom), fe, 16'($urandom)}, 1'b0);
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 45) : $urandom_range(0, 8);
                repeat (n) queue_word($urandom, 1'b0);
                queued += 2 + n;
                case ($urandom_range(0, 2))
                    0:
                    begin
                        queue_word(afsd_pkg::TRAILER_WORD, $urandom_range(0, 3) == 0);
                        queued++;
                    end
                    1: ;
                    default:
                    begin
                        queue_word($urandom, 1'b1);
                        queued++;
                    end
                endcase
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: queue_word(afsd_pkg::TRAILER_WORD, $urandom_range(0, 7) == 0);
                    1: queue_word({afsd_pkg::HDR_TAG, 8'($urandom)}, $urandom_range(0, 7) == 0);
                    default: queue_word($urandom, $urandom_range(0, 7) == 0);
                endcase
                queued++;
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        queue_word(32'hfafafafa, 1'b0);     // nothing held: trailer look-alike is held
        queue_word(32'h41444305, 1'b0);     // header with no open frame
        queue_word(32'h00020000, 1'b0);
        queue_word(32'h41444300, 1'b0);     // nothing held: header look-alike is held
        queue_word(32'h12345678, 1'b0);
        queue_word(32'hffffffff, 1'b0);
        queue_word(32'h00000000, 1'b0);
        queue_word(32'h41444200, 1'b0);
        queue_word(32'hfafafafa, 1'b0);
        queue_word(32'h414443ff, 1'b0);
        queue_word(32'h41444311, 1'b0);     // channel out of range
        queue_word(32'h00ff0000, 1'b0);     // front end out of range
        queue_word(32'ha5a5a5a5, 1'b0);
        queue_word(32'h5a5a5a5a, 1'b0);
        queue_word(32'h01020304, 1'b1);
        queue_word(32'hdeadbeef, 1'b1);     // buffer end with nothing held
        queue_word(32'hc0ffee00, 1'b0);
        queue_word(32'h4144430f, 1'b0);
        queue_word(32'h00030000, 1'b1);     // buffer end on front-end word
        queue_word(32'h11111111, 1'b0);
        queue_word(32'hfafafafa, 1'b1);
        queue_word(32'h22222222, 1'b0);
        queue_word(32'h33333333, 1'b1);
        queue_word(32'h44444444, 1'b0);
        queue_word(32'h41444302, 1'b1);
        settle();

        write_reg(afsd_pkg::REG_ACTIVE_MASK, {$urandom, $urandom});
        write_reg(afsd_pkg::REG_MIN_SAMPLES, 64'd0);
        queue_random_words(95);
        settle();

        write_reg(afsd_pkg::REG_ACTIVE_MASK, 64'd0);
        write_reg(afsd_pkg::REG_MIN_SAMPLES, 64'd4095);
        queue_random_words(95);
        settle();

        write_reg(afsd_pkg::REG_ACTIVE_MASK, {$urandom, $urandom});
        write_reg(afsd_pkg::REG_MIN_SAMPLES, 64'($urandom_range(0, 40)));
        queue_random_words(95);
        settle();

        write_reg(afsd_pkg::REG_ACTIVE_MASK, afsd_pkg::MASK_RESET);
        write_reg(afsd_pkg::REG_MIN_SAMPLES, 64'($urandom_range(0, 40)));
        queue_random_words(95);
        settle();
        repeat (12) @(posedge clk);

        if (mismatches == 0 && predicted_results.size() == 0)
            $display("PASS adc_frame_stream_deframer_top");
        else
            $display("FAIL adc_frame_stream_deframer_top");
        $finish;
    end

endmodule
